/* rtl/wcoc_pkg.sv */
// wcoc_pkg: shared types and constants for the waypoint course-out check.
// Holds request/result structs, command and state enums, and field widths.
// No dependencies.
package wcoc_pkg;

    localparam int COORD_WIDTH    = 24;
    localparam int IDX_WIDTH      = 10;
    localparam int THR_WIDTH      = 23;
    localparam int CNT_WIDTH      = 11;
    localparam int CFG_ADDR_WIDTH = 2;
    localparam int PT_WIDTH       = 2 * COORD_WIDTH;
    localparam int DIFF_WIDTH     = COORD_WIDTH + 1;
    localparam int SQ_WIDTH       = 2 * DIFF_WIDTH;
    localparam int SUM_WIDTH      = SQ_WIDTH + 1;
    localparam int LIM_WIDTH      = 2 * THR_WIDTH;

    localparam logic [1:0] REQ_WR_INNER = 2'd0;
    localparam logic [1:0] REQ_WR_OUTER = 2'd1;
    localparam logic [1:0] REQ_QUERY    = 2'd2;

    localparam logic [CFG_ADDR_WIDTH-1:0] CFG_THRESHOLD   = 2'd0;
    localparam logic [CFG_ADDR_WIDTH-1:0] CFG_INNER_COUNT = 2'd1;
    localparam logic [CFG_ADDR_WIDTH-1:0] CFG_OUTER_COUNT = 2'd2;

    localparam logic [THR_WIDTH-1:0] THRESHOLD_RESET = 23'd256;

    typedef struct packed {
        logic [1:0]                    req_type;
        logic [IDX_WIDTH-1:0]          entry_index;
        logic signed [COORD_WIDTH-1:0] pos_x;
        logic signed [COORD_WIDTH-1:0] pos_y;
    } in_item_t;

    typedef struct packed {
        logic is_out;
        logic inner_far;
        logic outer_far;
    } out_item_t;

    typedef enum logic [1:0] {
        CMD_WR_INNER,
        CMD_WR_OUTER,
        CMD_QUERY
    } cmd_op_t;

    typedef struct packed {
        cmd_op_t                       op;
        logic [IDX_WIDTH-1:0]          addr;
        logic signed [COORD_WIDTH-1:0] x;
        logic signed [COORD_WIDTH-1:0] y;
    } cmd_t;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_SCAN,
        BK_DRAIN
    } back_state_t;

    typedef struct packed {
        logic busy;
        logic result_load;
    } back_status_t;

endpackage

/* rtl/wcoc_front.sv */
// wcoc_front: request decode and two-entry command queue.
// Drops unknown requests and out-of-range writes; feeds wcoc_back.
// Depends on wcoc_pkg.
module wcoc_front #(
    parameter int MAX_POINTS = 1024
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    output logic               full,
    input  wcoc_pkg::in_item_t item,
    output logic               cmd_valid,
    output wcoc_pkg::cmd_t     cmd,
    input  logic               cmd_pop
);

    logic              keep;
    logic              in_range;
    wcoc_pkg::cmd_op_t op;
    logic              enq;
    logic              deq;

    wcoc_pkg::cmd_t    q_reg [2];
    logic              wr_ptr_reg;
    logic              wr_ptr_next;
    logic              rd_ptr_reg;
    logic              rd_ptr_next;
    logic [1:0]        cnt_reg;
    logic [1:0]        cnt_next;

    assign in_range = 32'(item.entry_index) < 32'(MAX_POINTS);

    always_comb
    begin
        keep = 1'b0;
        op   = wcoc_pkg::CMD_QUERY;
        unique case (item.req_type)
            wcoc_pkg::REQ_WR_INNER:
            begin
                op   = wcoc_pkg::CMD_WR_INNER;
                keep = in_range;
            end
            wcoc_pkg::REQ_WR_OUTER:
            begin
                op   = wcoc_pkg::CMD_WR_OUTER;
                keep = in_range;
            end
            wcoc_pkg::REQ_QUERY:
            begin
                op   = wcoc_pkg::CMD_QUERY;
                keep = 1'b1;
            end
            default:
            begin
                op   = wcoc_pkg::CMD_QUERY;
                keep = 1'b0;
            end
        endcase
    end

    assign full      = cnt_reg == 2'd2;
    assign cmd_valid = cnt_reg != 2'd0;
    assign cmd       = q_reg[rd_ptr_reg];
    assign enq       = push && !full && keep;
    assign deq       = cmd_pop && cmd_valid;

    always_comb
    begin
        wr_ptr_next = enq ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = deq ? !rd_ptr_reg : rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (enq && !deq)
        begin
            cnt_next = cnt_reg + 2'd1;
        end
        else if (deq && !enq)
        begin
            cnt_next = cnt_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (enq)
        begin
            q_reg[wr_ptr_reg] <= '{op: op, addr: item.entry_index,
                                   x: item.pos_x, y: item.pos_y};
        end
    end

endmodule

/* rtl/wcoc_back.sv */
// wcoc_back: waypoint tables, parallel scan of both lanes and result register.
// Four-stage distance pipeline: read, abs diff, square, sum and compare.
// Depends on wcoc_pkg; takes commands from wcoc_front.
module wcoc_back #(
    parameter int MAX_POINTS = 1024
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cmd_valid,
    input  wcoc_pkg::cmd_t                      cmd,
    output logic                                cmd_pop,
    input  logic [wcoc_pkg::THR_WIDTH-1:0]      threshold,
    input  logic [wcoc_pkg::CNT_WIDTH-1:0]      inner_count,
    input  logic [wcoc_pkg::CNT_WIDTH-1:0]      outer_count,
    output logic                                empty,
    input  logic                                pop,
    output wcoc_pkg::out_item_t                 result,
    output wcoc_pkg::back_status_t              status
);

    localparam int AW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
    localparam int CW = $clog2(MAX_POINTS + 1);

    function automatic logic [CW-1:0] clamp_count(
        input logic [wcoc_pkg::CNT_WIDTH-1:0] c
    );
        if (32'(c) > 32'(MAX_POINTS))
        begin
            clamp_count = CW'(MAX_POINTS);
        end
        else
        begin
            clamp_count = CW'(c);
        end
    endfunction

    function automatic logic [wcoc_pkg::DIFF_WIDTH-1:0] abs_diff(
        input logic signed [wcoc_pkg::COORD_WIDTH-1:0] a,
        input logic signed [wcoc_pkg::COORD_WIDTH-1:0] b
    );
        logic signed [wcoc_pkg::DIFF_WIDTH-1:0] d;
        d = wcoc_pkg::DIFF_WIDTH'(a) - wcoc_pkg::DIFF_WIDTH'(b);
        abs_diff = d[wcoc_pkg::DIFF_WIDTH-1] ? wcoc_pkg::DIFF_WIDTH'(-d)
                                             : wcoc_pkg::DIFF_WIDTH'(d);
    endfunction

    wcoc_pkg::back_state_t state_reg;
    wcoc_pkg::back_state_t state_next;

    logic [wcoc_pkg::PT_WIDTH-1:0] mem_in  [MAX_POINTS];
    logic [wcoc_pkg::PT_WIDTH-1:0] mem_out [MAX_POINTS];
    logic [wcoc_pkg::PT_WIDTH-1:0] rd_in_reg;
    logic [wcoc_pkg::PT_WIDTH-1:0] rd_out_reg;

    logic [CW-1:0] nin;
    logic [CW-1:0] nout;
    logic [CW-1:0] nin_reg;
    logic [CW-1:0] nout_reg;
    logic [CW-1:0] nmax_reg;
    logic [CW-1:0] cnt_reg;
    logic [CW-1:0] cnt_next;
    logic [CW-1:0] cnt_inc;

    logic signed [wcoc_pkg::COORD_WIDTH-1:0] qx_reg;
    logic signed [wcoc_pkg::COORD_WIDTH-1:0] qy_reg;
    logic [wcoc_pkg::LIM_WIDTH-1:0]          lim_reg;

    logic wr_in;
    logic wr_out;
    logic start;
    logic rd_issue;
    logic pipe_busy;
    logic load;

    logic s1_vin_reg;
    logic s1_vout_reg;
    logic s2_vin_reg;
    logic s2_vout_reg;
    logic s3_vin_reg;
    logic s3_vout_reg;

    logic [wcoc_pkg::DIFF_WIDTH-1:0] dxi_reg;
    logic [wcoc_pkg::DIFF_WIDTH-1:0] dyi_reg;
    logic [wcoc_pkg::DIFF_WIDTH-1:0] dxo_reg;
    logic [wcoc_pkg::DIFF_WIDTH-1:0] dyo_reg;
    logic [wcoc_pkg::SQ_WIDTH-1:0]   sxi_reg;
    logic [wcoc_pkg::SQ_WIDTH-1:0]   syi_reg;
    logic [wcoc_pkg::SQ_WIDTH-1:0]   sxo_reg;
    logic [wcoc_pkg::SQ_WIDTH-1:0]   syo_reg;
    logic [wcoc_pkg::SUM_WIDTH-1:0]  sum_in;
    logic [wcoc_pkg::SUM_WIDTH-1:0]  sum_out;

    logic near_in_reg;
    logic near_out_reg;
    logic out_valid_reg;
    logic out_valid_next;
    wcoc_pkg::out_item_t result_reg;

    assign nin       = clamp_count(inner_count);
    assign nout      = clamp_count(outer_count);
    assign cnt_inc   = CW'(cnt_reg + 1'b1);
    assign pipe_busy = s1_vin_reg || s1_vout_reg || s2_vin_reg || s2_vout_reg
                       || s3_vin_reg || s3_vout_reg;
    assign rd_issue  = state_reg == wcoc_pkg::BK_SCAN;

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        cmd_pop    = 1'b0;
        wr_in      = 1'b0;
        wr_out     = 1'b0;
        start      = 1'b0;
        load       = 1'b0;
        unique case (state_reg)
            wcoc_pkg::BK_IDLE:
            begin
                if (cmd_valid)
                begin
                    cmd_pop = 1'b1;
                    unique case (cmd.op)
                        wcoc_pkg::CMD_WR_INNER: wr_in  = 1'b1;
                        wcoc_pkg::CMD_WR_OUTER: wr_out = 1'b1;
                        wcoc_pkg::CMD_QUERY:
                        begin
                            start    = 1'b1;
                            cnt_next = '0;
                            if (nin == '0 && nout == '0)
                            begin
                                state_next = wcoc_pkg::BK_DRAIN;
                            end
                            else
                            begin
                                state_next = wcoc_pkg::BK_SCAN;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            wcoc_pkg::BK_SCAN:
            begin
                cnt_next = cnt_inc;
                if (cnt_inc == nmax_reg)
                begin
                    state_next = wcoc_pkg::BK_DRAIN;
                end
            end
            wcoc_pkg::BK_DRAIN:
            begin
                if (!pipe_busy && (!out_valid_reg || pop))
                begin
                    load       = 1'b1;
                    state_next = wcoc_pkg::BK_IDLE;
                end
            end
            default: state_next = wcoc_pkg::BK_IDLE;
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (load)
        begin
            out_valid_next = 1'b1;
        end
        else if (pop)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= wcoc_pkg::BK_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
            s1_vin_reg    <= 1'b0;
            s1_vout_reg   <= 1'b0;
            s2_vin_reg    <= 1'b0;
            s2_vout_reg   <= 1'b0;
            s3_vin_reg    <= 1'b0;
            s3_vout_reg   <= 1'b0;
            near_in_reg   <= 1'b0;
            near_out_reg  <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
            s1_vin_reg    <= rd_issue && (cnt_reg < nin_reg);
            s1_vout_reg   <= rd_issue && (cnt_reg < nout_reg);
            s2_vin_reg    <= s1_vin_reg;
            s2_vout_reg   <= s1_vout_reg;
            s3_vin_reg    <= s2_vin_reg;
            s3_vout_reg   <= s2_vout_reg;
            if (start)
            begin
                near_in_reg  <= 1'b0;
                near_out_reg <= 1'b0;
            end
            else
            begin
                if (s3_vin_reg && sum_in <= wcoc_pkg::SUM_WIDTH'(lim_reg))
                begin
                    near_in_reg <= 1'b1;
                end
                if (s3_vout_reg && sum_out <= wcoc_pkg::SUM_WIDTH'(lim_reg))
                begin
                    near_out_reg <= 1'b1;
                end
            end
        end
    end

    // query setup
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            qx_reg   <= cmd.x;
            qy_reg   <= cmd.y;
            nin_reg  <= nin;
            nout_reg <= nout;
            nmax_reg <= (nin > nout) ? nin : nout;
            lim_reg  <= wcoc_pkg::LIM_WIDTH'(threshold) * wcoc_pkg::LIM_WIDTH'(threshold);
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_in)
        begin
            mem_in[AW'(cmd.addr)] <= {cmd.x, cmd.y};
        end
        if (rd_issue)
        begin
            rd_in_reg <= mem_in[cnt_reg[AW-1:0]];
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_out)
        begin
            mem_out[AW'(cmd.addr)] <= {cmd.x, cmd.y};
        end
        if (rd_issue)
        begin
            rd_out_reg <= mem_out[cnt_reg[AW-1:0]];
        end
    end

    always_ff @(posedge clk)
    begin
        dxi_reg <= abs_diff(rd_in_reg[wcoc_pkg::PT_WIDTH-1:wcoc_pkg::COORD_WIDTH], qx_reg);
        dyi_reg <= abs_diff(rd_in_reg[wcoc_pkg::COORD_WIDTH-1:0], qy_reg);
        dxo_reg <= abs_diff(rd_out_reg[wcoc_pkg::PT_WIDTH-1:wcoc_pkg::COORD_WIDTH], qx_reg);
        dyo_reg <= abs_diff(rd_out_reg[wcoc_pkg::COORD_WIDTH-1:0], qy_reg);
        sxi_reg <= wcoc_pkg::SQ_WIDTH'(dxi_reg) * wcoc_pkg::SQ_WIDTH'(dxi_reg);
        syi_reg <= wcoc_pkg::SQ_WIDTH'(dyi_reg) * wcoc_pkg::SQ_WIDTH'(dyi_reg);
        sxo_reg <= wcoc_pkg::SQ_WIDTH'(dxo_reg) * wcoc_pkg::SQ_WIDTH'(dxo_reg);
        syo_reg <= wcoc_pkg::SQ_WIDTH'(dyo_reg) * wcoc_pkg::SQ_WIDTH'(dyo_reg);
    end

    assign sum_in  = wcoc_pkg::SUM_WIDTH'(sxi_reg) + wcoc_pkg::SUM_WIDTH'(syi_reg);
    assign sum_out = wcoc_pkg::SUM_WIDTH'(sxo_reg) + wcoc_pkg::SUM_WIDTH'(syo_reg);

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            result_reg.inner_far <= !near_in_reg;
            result_reg.outer_far <= !near_out_reg;
            result_reg.is_out    <= !near_in_reg && !near_out_reg;
        end
    end

    assign empty              = !out_valid_reg;
    assign result             = result_reg;
    assign status.busy        = state_reg != wcoc_pkg::BK_IDLE;
    assign status.result_load = load;

endmodule

/* rtl/waypoint_course_out_check_unit.sv */
// waypoint_course_out_check_unit: top level, configuration registers and assertions.
// Instantiates wcoc_front and wcoc_back; depends on wcoc_pkg.
//
// Usage:
//   Requests enter through push/full as in_item_t: write inner point, write outer
//   point, query. Unknown types and writes to a slot at or beyond MAX_POINTS are
//   taken and dropped. Only queries give a result, through empty/pop as out_item_t,
//   oldest first. Registers threshold, inner_count, outer_count are written by cfg_we
//   with cfg_addr/cfg_wdata; the user must write them only while the unit is idle, as
//   the unit does not enforce it. Counts above MAX_POINTS clamp.
// Timing:
//   A two-entry command queue sits between decode and execution. Point writes
//   stream at one per cycle while no query holds the execution side. A query scans
//   both tables in parallel, one entry of each per cycle over max(inner, outer)
//   entries, then drains a four-stage distance pipeline. With both lanes empty it
//   skips the scan. The query holds the execution side until its result is loaded.
// Reset: queue and result register empty, threshold 256, counts 0. Table
//   contents are undefined until written.
// Stall: a result waits in the output register until popped; the next query
//   scans meanwhile and holds at its end, and the queue fills until full.
module waypoint_course_out_check_unit #(
    parameter int MAX_POINTS = 1024
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  push,
    output logic                                  full,
    input  wcoc_pkg::in_item_t                    item,
    output logic                                  empty,
    input  logic                                  pop,
    output wcoc_pkg::out_item_t                   result,
    input  logic                                  cfg_we,
    input  logic [wcoc_pkg::CFG_ADDR_WIDTH-1:0]   cfg_addr,
    input  logic [wcoc_pkg::THR_WIDTH-1:0]        cfg_wdata
);

    logic [wcoc_pkg::THR_WIDTH-1:0] threshold_reg;
    logic [wcoc_pkg::CNT_WIDTH-1:0] inner_count_reg;
    logic [wcoc_pkg::CNT_WIDTH-1:0] outer_count_reg;

    logic                   cmd_valid;
    wcoc_pkg::cmd_t         cmd;
    logic                   cmd_pop;
    wcoc_pkg::back_status_t bk_status;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            threshold_reg   <= wcoc_pkg::THRESHOLD_RESET;
            inner_count_reg <= '0;
            outer_count_reg <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_addr)
                wcoc_pkg::CFG_THRESHOLD:   threshold_reg   <= cfg_wdata;
                wcoc_pkg::CFG_INNER_COUNT:
                    inner_count_reg <= cfg_wdata[wcoc_pkg::CNT_WIDTH-1:0];
                wcoc_pkg::CFG_OUTER_COUNT:
                    outer_count_reg <= cfg_wdata[wcoc_pkg::CNT_WIDTH-1:0];
                default: ;
            endcase
        end
    end

    wcoc_front #(
        .MAX_POINTS (MAX_POINTS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .item      (item),
        .cmd_valid (cmd_valid),
        .cmd       (cmd),
        .cmd_pop   (cmd_pop)
    );

    wcoc_back #(
        .MAX_POINTS (MAX_POINTS)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd_valid   (cmd_valid),
        .cmd         (cmd),
        .cmd_pop     (cmd_pop),
        .threshold   (threshold_reg),
        .inner_count (inner_count_reg),
        .outer_count (outer_count_reg),
        .empty       (empty),
        .pop         (pop),
        .result      (result),
        .status      (bk_status)
    );

`ifndef NO_ASSERTIONS
    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_pop |-> cmd_valid)
        else $error("command popped from empty queue");

    a_pop_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_pop |-> !bk_status.busy)
        else $error("command popped during a query");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        bk_status.result_load |-> (empty || pop))
        else $error("result register overwritten");

    a_load_busy: assert property (@(posedge clk) disable iff (!rst_n)
        bk_status.result_load |=> !empty)
        else $error("loaded result not shown");

    a_full_has_cmd: assert property (@(posedge clk) disable iff (!rst_n)
        full |-> cmd_valid)
        else $error("full queue without command");
`endif

endmodule

/* tb/sv/tb_waypoint_course_out_check_unit.sv */
`timescale 1ns / 100ps
// tb_waypoint_course_out_check_unit: self-checking bench for the waypoint course-out unit.
// Loads both lanes, runs directed and random position queries, and checks every verdict
// against an in-bench nearest-point model. Depends on wcoc_pkg and the unit RTL.
module tb_waypoint_course_out_check_unit;

    localparam int LANE_DEPTH    = 1024;
    localparam int LANE_INNER    = 0;
    localparam int LANE_OUTER    = 1;
    localparam int SETTLE_CYCLES = 32;
    localparam int RANDOM_PHASES = 10;
    localparam int PHASE_MIX     = 32;
    localparam int IW            = wcoc_pkg::IDX_WIDTH;

    typedef logic [wcoc_pkg::COORD_WIDTH-1:0] coord_t;
    typedef logic [wcoc_pkg::THR_WIDTH-1:0]   thr_t;

    localparam logic [1:0]                              REQ_UNKNOWN = 2'd3;
    localparam logic [wcoc_pkg::CFG_ADDR_WIDTH-1:0]     CFG_UNUSED  = 2'd3;
    localparam logic signed [wcoc_pkg::COORD_WIDTH-1:0] COORD_MAX   = 24'sh7FFFFF;
    localparam logic signed [wcoc_pkg::COORD_WIDTH-1:0] COORD_MIN   = 24'sh800000;
    localparam logic [wcoc_pkg::THR_WIDTH-1:0]          THR_MAX     = 23'h7FFFFF;

    logic                                clk;
    logic                                rst_n;
    logic                                push;
    logic                                full;
    wcoc_pkg::in_item_t                  item;
    logic                                empty;
    logic                                pop;
    wcoc_pkg::out_item_t                 result;
    logic                                cfg_we;
    logic [wcoc_pkg::CFG_ADDR_WIDTH-1:0] cfg_addr;
    logic [wcoc_pkg::THR_WIDTH-1:0]      cfg_wdata;

    logic signed [wcoc_pkg::COORD_WIDTH-1:0] lane_x [2][LANE_DEPTH];
    logic signed [wcoc_pkg::COORD_WIDTH-1:0] lane_y [2][LANE_DEPTH];
    logic [wcoc_pkg::CNT_WIDTH-1:0]          lane_count [2];
    logic [wcoc_pkg::THR_WIDTH-1:0]          course_limit;
    wcoc_pkg::out_item_t                     verdict_q [$];
    int                                      error_count;
    bit                                      no_idle;

    waypoint_course_out_check_unit u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .item      (item),
        .empty     (empty),
        .pop       (pop),
        .result    (result),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    function automatic bit lane_far(input int lane,
                                    input logic signed [wcoc_pkg::COORD_WIDTH-1:0] qx,
                                    input logic signed [wcoc_pkg::COORD_WIDTH-1:0] qy);
        int     n;
        longint dx;
        longint dy;
        longint d;
        longint best;
        longint lim;
        n = (lane_count[lane[0]] > LANE_DEPTH) ? LANE_DEPTH : int'(lane_count[lane[0]]);
        if (n == 0)
            return 1'b1;
        lim  = longint'(course_limit) * longint'(course_limit);
        best = 64'sh7FFF_FFFF_FFFF_FFFF;
        for (int i = 0; i < n; i++)
        begin
            dx = longint'(lane_x[lane[0]][i[IW-1:0]]) - longint'(qx);
            dy = longint'(lane_y[lane[0]][i[IW-1:0]]) - longint'(qy);
            d  = dx * dx + dy * dy;
            if (d < best)
                best = d;
        end
        return best > lim;
    endfunction

    function automatic wcoc_pkg::out_item_t predict_verdict(
        input logic signed [wcoc_pkg::COORD_WIDTH-1:0] qx,
        input logic signed [wcoc_pkg::COORD_WIDTH-1:0] qy);
        wcoc_pkg::out_item_t v;
        v.inner_far = lane_far(LANE_INNER, qx, qy);
        v.outer_far = lane_far(LANE_OUTER, qx, qy);
        v.is_out    = v.inner_far & v.outer_far;
        return v;
    endfunction

    function automatic wcoc_pkg::in_item_t make_req(input logic [1:0] kind, input int slot,
                                                    input coord_t x, input coord_t y);
        wcoc_pkg::in_item_t r;
        r.req_type    = kind;
        r.entry_index = slot[IW-1:0];
        r.pos_x       = x;
        r.pos_y       = y;
        return r;
    endfunction

    function automatic coord_t jitter(input coord_t c, input int reach);
        int off;
        off = int'($urandom_range(0, 2 * reach)) - reach;
        return c + off[wcoc_pkg::COORD_WIDTH-1:0];
    endfunction

    function automatic thr_t count_word(input int n);
        thr_t w;
        w = thr_t'($urandom());
        w[wcoc_pkg::CNT_WIDTH-1:0] = n[wcoc_pkg::CNT_WIDTH-1:0];
        return w;
    endfunction

    function automatic int lane_size();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 10)
            return 0;
        else if (pick < 80)
            return $urandom_range(1, 16);
        return $urandom_range(17, 64);
    endfunction

    // one request, held until accepted; the model is updated at the accepting edge
    task automatic send_req(input wcoc_pkg::in_item_t r);
        while (!no_idle && $urandom_range(0, 99) < 23)
        begin
            push <= 1'b0;
            @(posedge clk);
        end
        push <= 1'b1;
        item <= r;
        do
            @(posedge clk);
        while (full);
        case (r.req_type)
            wcoc_pkg::REQ_WR_INNER, wcoc_pkg::REQ_WR_OUTER:
            begin
                lane_x[r.req_type[0]][r.entry_index] = r.pos_x;
                lane_y[r.req_type[0]][r.entry_index] = r.pos_y;
            end
            wcoc_pkg::REQ_QUERY:
                verdict_q.push_back(predict_verdict(r.pos_x, r.pos_y));
            default:
                ;
        endcase
    endtask

    task automatic put_point(input int lane, input int slot, input coord_t x,
                             input coord_t y);
        send_req(make_req((lane == LANE_INNER) ? wcoc_pkg::REQ_WR_INNER
                                               : wcoc_pkg::REQ_WR_OUTER, slot, x, y));
    endtask

    task automatic query(input coord_t x, input coord_t y);
        send_req(make_req(wcoc_pkg::REQ_QUERY, $urandom(), x, y));
    endtask

    task automatic wait_idle();
        push <= 1'b0;
        while (verdict_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [wcoc_pkg::CFG_ADDR_WIDTH-1:0] addr,
                             input thr_t data);
        cfg_we    <= 1'b1;
        cfg_addr  <= addr;
        cfg_wdata <= data;
        @(posedge clk);
        case (addr)
            wcoc_pkg::CFG_THRESHOLD:   course_limit = data;
            wcoc_pkg::CFG_INNER_COUNT:
                lane_count[LANE_INNER] = data[wcoc_pkg::CNT_WIDTH-1:0];
            wcoc_pkg::CFG_OUTER_COUNT:
                lane_count[LANE_OUTER] = data[wcoc_pkg::CNT_WIDTH-1:0];
            default:         ;
        endcase
    endtask

    // counts carry random upper bits; a stray write to the unused index comes last
    task automatic apply_config(input thr_t thr, input int n_in, input int n_out,
                                input bit stray);
        write_reg(wcoc_pkg::CFG_THRESHOLD, thr);
        write_reg(wcoc_pkg::CFG_INNER_COUNT, count_word(n_in));
        write_reg(wcoc_pkg::CFG_OUTER_COUNT, count_word(n_out));
        if (stray)
            write_reg(CFG_UNUSED, thr_t'($urandom()));
        cfg_we <= 1'b0;
    endtask

    task automatic check_field(input string name, input logic want, input logic got);
        if (got !== want)
        begin
            error_count++;
            $display("%0t: %s mismatch, expected %0b, actual %0b", $time, name, want, got);
        end
    endtask

    always @(posedge clk)
    begin : result_monitor
        wcoc_pkg::out_item_t want;
        if (rst_n === 1'b1 && pop === 1'b1 && empty === 1'b0)
        begin
            if (verdict_q.size() == 0)
            begin
                error_count++;
                $display("%0t: result with no pending query, expected none, actual %b",
                         $time, result);
            end
            else
            begin
                want = verdict_q.pop_front();
                check_field("is_out", want.is_out, result.is_out);
                check_field("inner_far", want.inner_far, result.inner_far);
                check_field("outer_far", want.outer_far, result.outer_far);
            end
        end
        pop <= no_idle || ($urandom_range(0, 99) >= 23);
    end

    task automatic test_empty_lanes();
        query(24'd0, 24'd0);
        send_req(make_req(REQ_UNKNOWN, $urandom(), coord_t'($urandom()),
                          coord_t'($urandom())));
    endtask

    task automatic test_boundaries();
        put_point(LANE_INNER, 0, 24'd0, 24'd0);
        put_point(LANE_OUTER, 0, 24'd1000, 24'd0);
        put_point(LANE_INNER, LANE_DEPTH - 1, COORD_MAX, COORD_MAX);
        put_point(LANE_OUTER, LANE_DEPTH - 1, COORD_MIN, COORD_MIN);
        wait_idle();
        apply_config(wcoc_pkg::THRESHOLD_RESET, 1, 1, 1'b1);
        query(24'd256, 24'd0);
        query(24'd257, 24'd0);
        query(24'd1000, 24'd0);
        query(COORD_MAX, COORD_MAX);
        query(COORD_MIN, COORD_MIN);
        wait_idle();
        apply_config('0, 1, 1, 1'b0);
        query(24'd0, 24'd0);
        query(24'd1, 24'd0);
        wait_idle();
        apply_config(23'd5, 1, 1, 1'b0);
        query(24'd3, 24'd4);
        query(-24'sd3, -24'sd5);
        wait_idle();
        apply_config(THR_MAX, 1, 1, 1'b0);
        query(COORD_MAX, COORD_MAX);
        query(24'd0, 24'd0);
        query(COORD_MIN, 24'd0);
        wait_idle();
    endtask

    task automatic test_random_traffic();
        int     n_in;
        int     n_out;
        int     spread;
        int     reach;
        int     pick;
        int     lane;
        int     slot;
        int     top;
        coord_t bx;
        coord_t by;
        coord_t px;
        coord_t py;
        thr_t   thr;
        for (int p = 0; p < RANDOM_PHASES; p++)
        begin
            no_idle = (p == 3) || (p == 4);
            n_in    = lane_size();
            n_out   = lane_size();
            spread  = 1 << $urandom_range(4, 16);
            bx      = coord_t'($urandom());
            by      = coord_t'($urandom());
            top     = (n_in > n_out) ? n_in : n_out;
            for (int i = 0; i < top; i++)
            begin
                if (i < n_in)
                    put_point(LANE_INNER, i, jitter(bx, spread), jitter(by, spread));
                if (i < n_out)
                    put_point(LANE_OUTER, i, jitter(bx, spread), jitter(by, spread));
            end
            wait_idle();
            pick = $urandom_range(0, 99);
            if (pick < 10)
                thr = '0;
            else if (pick < 20)
                thr = THR_MAX;
            else if (pick < 40)
                thr = thr_t'($urandom());
            else
                thr = thr_t'($urandom_range(0, 2 * spread));
            apply_config(thr, n_in, n_out, $urandom_range(0, 4) == 0);
            reach = int'(thr) + int'(thr) / 4 + 2;
            for (int k = 0; k < PHASE_MIX; k++)
            begin
                pick = $urandom_range(0, 99);
                lane = $urandom_range(LANE_INNER, LANE_OUTER);
                if ((lane == LANE_INNER) ? (n_in == 0) : (n_out == 0))
                    lane = 1 - lane;
                top = (lane == LANE_INNER) ? n_in : n_out;
                if (top == 0)
                begin
                    slot = 0;
                    px   = bx;
                    py   = by;
                end
                else
                begin
                    slot = $urandom_range(0, top - 1);
                    px   = lane_x[lane[0]][slot[IW-1:0]];
                    py   = lane_y[lane[0]][slot[IW-1:0]];
                end
                if (pick < 62)
                    query(jitter(px, reach), jitter(py, reach));
                else if (pick < 68)
                    query(px + coord_t'(thr), py);
                else if (pick < 74)
                    query(px, py);
                else if (pick < 82)
                    query(coord_t'($urandom()), coord_t'($urandom()));
                else if (pick < 90 && top != 0)
                    put_point(lane, slot, jitter(bx, spread), jitter(by, spread));
                else if (pick < 95)
                    put_point(lane, $urandom_range(0, LANE_DEPTH - 1), coord_t'($urandom()),
                              coord_t'($urandom()));
                else
                    send_req(make_req(REQ_UNKNOWN, $urandom(), coord_t'($urandom()),
                                      coord_t'($urandom())));
            end
            wait_idle();
        end
        no_idle = 1'b0;
    endtask

    initial
    begin
        rst_n     <= 1'b0;
        push      <= 1'b0;
        item      <= '0;
        cfg_we    <= 1'b0;
        cfg_addr  <= '0;
        cfg_wdata <= '0;
        error_count  = 0;
        no_idle      = 1'b0;
        course_limit = wcoc_pkg::THRESHOLD_RESET;
        lane_count[LANE_INNER] = '0;
        lane_count[LANE_OUTER] = '0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        test_empty_lanes();
        test_boundaries();
        test_random_traffic();
        wait_idle();
        if (error_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

    initial
    begin
        #(50_000_000);
        $display("status: fail");
        $finish;
    end

endmodule

/* waypoint_course_out_check_unit.f */
rtl/wcoc_pkg.sv
rtl/wcoc_front.sv
rtl/wcoc_back.sv
rtl/waypoint_course_out_check_unit.sv
tb/sv/tb_waypoint_course_out_check_unit.sv
